@@ rtl/ialu_pkg.sv @@
// ----------------------------------------------------------------------------
// ialu_pkg: shared definitions for the integer ALU with GCD and LCM
// Widths, operation and status codes used by the interfaces, the ALU and
// its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ialu_pkg;

	// Number of low operand bits that take part; they are sign-extended from the top one.
	localparam int DATA_WIDTH = 32;
	// Fixed widths of the operand and result fields.
	localparam int OPND_W = 32;
	localparam int RES_W  = 64;
	// Step counter: counts up to RES_W - 1 for a wide division.
	localparam int CNT_W  = $clog2(RES_W);

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4,
		OP_GCD = 3'd5,
		OP_LCM = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

endpackage

`default_nettype wire

@@ rtl/ialu_if.sv @@
// ----------------------------------------------------------------------------
// ialu_if: request and response channels of the integer ALU
// Valid/ready channels; a word moves at a clock edge where both are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface ialu_req_if;
	logic                                    valid;
	logic                                    ready;
	logic [2:0]                              req_type;
	logic signed [ialu_pkg::OPND_W-1:0]      operand_a;
	logic signed [ialu_pkg::OPND_W-1:0]      operand_b;

	modport source (output valid, output req_type, output operand_a, output operand_b,
		input ready);
	modport sink (input valid, input req_type, input operand_a, input operand_b,
		output ready);
endinterface

interface ialu_rsp_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [ialu_pkg::RES_W-1:0]       result_value;
	logic [1:0]                              status_code;

	modport source (output valid, output result_value, output status_code, input ready);
	modport sink (input valid, input result_value, input status_code, output ready);
endinterface

`default_nettype wire

@@ rtl/integer_alu_with_gcd_lcm.sv @@
// ----------------------------------------------------------------------------
// integer_alu_with_gcd_lcm: sequential integer ALU with GCD and LCM
// Flow: add/sub finish in dispatch; multiply runs one shift-add step per
// multiplier bit; divide/remainder takes both magnitudes, one restoring step
// per dividend bit and two sign fixes; GCD runs one such division per Euclid
// step; LCM multiplies, runs the GCD, then divides the wide product by it.
// One word is in work at a time; the shared adder and the step loop set the
// rate. The next request is taken the cycle after a result reaches the output
// register. A finished word waits there, so the next request is taken while it is stalled.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and empties
// the output register; no other state survives between words.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_alu_with_gcd_lcm (
	input  wire logic       clk,
	input  wire logic       arst_n,
	ialu_req_if.sink        req,
	ialu_rsp_if.source      rsp
);

	localparam int DW    = ialu_pkg::DATA_WIDTH;
	localparam int RW    = ialu_pkg::RES_W;
	localparam int CW    = ialu_pkg::CNT_W;

	// The sequencer. Every arithmetic step of every operation goes through one
	// 64-bit adder/subtractor; the states only choose what feeds it and where
	// its sum lands.
	typedef enum logic [9:0] {
		S_IDLE     = 10'b00_0000_0001,  // waiting for a request word
		S_DISPATCH = 10'b00_0000_0010,  // decode, add/sub, error checks
		S_MUL      = 10'b00_0000_0100,  // one shift-add step per cycle
		S_GTEST    = 10'b00_0000_1000,  // Euclid loop test
		S_ABSN     = 10'b00_0001_0000,  // magnitude of the dividend
		S_ABSD     = 10'b00_0010_0000,  // magnitude of the divisor
		S_ITER     = 10'b00_0100_0000,  // one restoring division step
		S_FIXQ     = 10'b00_1000_0000,  // sign of the quotient
		S_FIXR     = 10'b01_0000_0000,  // sign of the remainder
		S_FIN      = 10'b10_0000_0000   // hand the word to the output register
	} state_t;

	function automatic logic [RW-1:0] sext_dw(input logic [DW-1:0] v);
		return {{(RW-DW){v[DW-1]}}, v};
	endfunction

	function automatic logic [RW-1:0] zext_dw(input logic [DW-1:0] v);
		return {{(RW-DW){1'b0}}, v};
	endfunction

	state_t              state_q;
	logic                ovalid_q;

	// Request word, low DATA_WIDTH bits of each operand.
	ialu_pkg::op_t       op_q;
	logic [DW-1:0]       a_q;
	logic [DW-1:0]       b_q;

	// Multiplier: accumulator, shifted multiplicand, multiplier bits.
	logic [RW-1:0]       acc_q;
	logic [RW-1:0]       mc_q;
	logic [DW-1:0]       mb_q;

	// Euclid pair.
	logic [DW-1:0]       x_q;
	logic [DW-1:0]       y_q;

	// Divider: signed operands, dividend/quotient shift word, partial remainder,
	// divisor magnitude, operand signs and the quotient after its sign fix.
	logic [RW-1:0]       num_q;
	logic [DW-1:0]       den_q;
	logic                short_q;       // dividend is DW bits wide, else RW bits
	logic                lcm_fin_q;     // the final division of an LCM
	logic [RW-1:0]       dq_q;
	logic [DW-1:0]       rem_q;
	logic [DW-1:0]       dvs_q;
	logic                sn_q;
	logic                sd_q;
	logic [RW-1:0]       quo_q;

	logic [CW-1:0]       cnt_q;

	logic [RW-1:0]       work_res_q;
	ialu_pkg::status_t   work_st_q;
	logic [RW-1:0]       out_res_q;
	ialu_pkg::status_t   out_st_q;

	// Shared adder.
	logic [RW-1:0]       add_x;
	logic [RW-1:0]       add_y;
	logic                add_sub;
	logic [RW-1:0]       add_sum;

	logic                out_free;
	logic                req_fire;
	logic                mul_last;
	logic                div_last;
	logic                b_zero;
	logic                div_ovf;
	logic [DW:0]         trial;
	logic                trial_ge;
	logic [RW-1:0]       num_mag;
	logic [RW-1:0]       den_mag;
	logic [RW-1:0]       quo_mag;
	logic [RW-1:0]       rem_signed;

	assign req.ready    = (state_q == S_IDLE);
	assign req_fire     = req.valid && req.ready;
	assign out_free     = !ovalid_q || rsp.ready;

	assign rsp.valid        = ovalid_q;
	assign rsp.result_value = out_res_q;
	assign rsp.status_code  = out_st_q;

	assign mul_last = (cnt_q == CW'(DW - 1));
	assign div_last = short_q ? (cnt_q == CW'(DW - 1)) : (cnt_q == CW'(RW - 1));
	assign b_zero   = (b_q == '0);
	// Most negative value divided by minus one has no representable quotient.
	assign div_ovf  = (a_q == {1'b1, {(DW-1){1'b0}}}) && (b_q == '1);

	// Restoring division: bring down the next dividend bit and try the divisor.
	assign trial    = {rem_q, dq_q[RW-1]};
	assign trial_ge = !add_sum[RW-1];

	assign num_mag    = num_q[RW-1] ? add_sum : num_q;
	assign den_mag    = den_q[DW-1] ? add_sum : sext_dw(den_q);
	assign quo_mag    = short_q ? zext_dw(dq_q[DW-1:0]) : dq_q;
	assign rem_signed = sn_q ? add_sum : zext_dw(rem_q);

	always_comb begin
		add_x   = '0;
		add_y   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_DISPATCH: begin
				add_x   = sext_dw(a_q);
				add_y   = sext_dw(b_q);
				add_sub = (op_q == ialu_pkg::OP_SUB);
			end
			S_MUL: begin
				// The top multiplier bit weighs negative in two's complement.
				add_x   = acc_q;
				add_y   = mb_q[0] ? mc_q : '0;
				add_sub = mb_q[0] && mul_last;
			end
			S_ABSN: begin
				add_y   = num_q;
				add_sub = 1'b1;
			end
			S_ABSD: begin
				add_y   = sext_dw(den_q);
				add_sub = 1'b1;
			end
			S_ITER: begin
				add_x   = {{(RW-DW-1){1'b0}}, trial};
				add_y   = zext_dw(dvs_q);
				add_sub = 1'b1;
			end
			S_FIXQ: begin
				add_y   = quo_mag;
				add_sub = 1'b1;
			end
			S_FIXR: begin
				add_y   = zext_dw(rem_q);
				add_sub = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign add_sum = add_x + (add_y ^ {RW{add_sub}}) + {{(RW-1){1'b0}}, add_sub};

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				ovalid_q <= 1'b1;
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_fire) begin
						state_q <= S_DISPATCH;
					end
				end
				S_DISPATCH: begin
					case (op_q)
						ialu_pkg::OP_MUL, ialu_pkg::OP_LCM: state_q <= S_MUL;
						ialu_pkg::OP_DIV: state_q <= (b_zero || div_ovf) ? S_FIN : S_ABSN;
						ialu_pkg::OP_REM: state_q <= b_zero ? S_FIN : S_ABSN;
						ialu_pkg::OP_GCD: state_q <= S_GTEST;
						default:          state_q <= S_FIN;
					endcase
				end
				S_MUL: begin
					if (mul_last) begin
						state_q <= (op_q == ialu_pkg::OP_MUL) ? S_FIN : S_GTEST;
					end
				end
				S_GTEST: begin
					if (y_q != '0) begin
						state_q <= S_ABSN;
					end else if (op_q == ialu_pkg::OP_LCM && x_q != '0) begin
						state_q <= S_ABSN;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_ABSN: state_q <= S_ABSD;
				S_ABSD: state_q <= S_ITER;
				S_ITER: begin
					if (div_last) begin
						state_q <= S_FIXQ;
					end
				end
				S_FIXQ: state_q <= S_FIXR;
				S_FIXR: begin
					if (op_q == ialu_pkg::OP_DIV || op_q == ialu_pkg::OP_REM || lcm_fin_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_GTEST;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					op_q <= ialu_pkg::op_t'(req.req_type);
					a_q  <= req.operand_a[DW-1:0];
					b_q  <= req.operand_b[DW-1:0];
				end
			end
			S_DISPATCH: begin
				// Add/sub finish here with the sum, division errors with zero; everything else starts from zero.
				work_res_q <= (op_q == ialu_pkg::OP_ADD || op_q == ialu_pkg::OP_SUB) ?
					add_sum : '0;
				lcm_fin_q  <= 1'b0;
				num_q      <= sext_dw(a_q);
				den_q      <= b_q;
				short_q    <= 1'b1;
				acc_q      <= '0;
				mc_q       <= sext_dw(a_q);
				mb_q       <= b_q;
				cnt_q      <= '0;
				x_q        <= a_q;
				y_q        <= b_q;
				if (b_zero && (op_q == ialu_pkg::OP_DIV || op_q == ialu_pkg::OP_REM)) begin
					work_st_q <= ialu_pkg::ST_DIV0;
				end else if (div_ovf && op_q == ialu_pkg::OP_DIV) begin
					work_st_q <= ialu_pkg::ST_OVF;
				end else begin
					work_st_q <= ialu_pkg::ST_OK;
				end
			end
			S_MUL: begin
				acc_q <= add_sum;
				mc_q  <= {mc_q[RW-2:0], 1'b0};
				mb_q  <= {1'b0, mb_q[DW-1:1]};
				cnt_q <= cnt_q + 1'b1;
				if (mul_last && op_q == ialu_pkg::OP_MUL) begin
					work_res_q <= add_sum;
				end
			end
			S_GTEST: begin
				if (y_q != '0) begin
					num_q   <= sext_dw(x_q);
					den_q   <= y_q;
					short_q <= 1'b1;
				end else if (op_q == ialu_pkg::OP_GCD) begin
					work_res_q <= sext_dw(x_q);
				end else if (x_q == '0) begin
					work_st_q <= ialu_pkg::ST_DIV0;
				end else begin
					// LCM: full-width product divided by the divisor just found.
					num_q     <= acc_q;
					den_q     <= x_q;
					short_q   <= 1'b0;
					lcm_fin_q <= 1'b1;
				end
			end
			S_ABSN: begin
				sn_q  <= num_q[RW-1];
				dq_q  <= short_q ? {num_mag[DW-1:0], {(RW-DW){1'b0}}} : num_mag;
				rem_q <= '0;
				cnt_q <= '0;
			end
			S_ABSD: begin
				sd_q  <= den_q[DW-1];
				dvs_q <= den_mag[DW-1:0];
			end
			S_ITER: begin
				rem_q <= trial_ge ? add_sum[DW-1:0] : trial[DW-1:0];
				dq_q  <= {dq_q[RW-2:0], trial_ge};
				cnt_q <= cnt_q + 1'b1;
			end
			S_FIXQ: begin
				quo_q <= (sn_q ^ sd_q) ? add_sum : quo_mag;
			end
			S_FIXR: begin
				if (op_q == ialu_pkg::OP_DIV || lcm_fin_q) begin
					work_res_q <= quo_q;
				end else if (op_q == ialu_pkg::OP_REM) begin
					work_res_q <= rem_signed;
				end else begin
					x_q <= y_q;
					y_q <= rem_signed[DW-1:0];
				end
			end
			S_FIN: begin
				if (out_free) begin
					out_res_q <= work_res_q;
					out_st_q  <= work_st_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ rtl/ialu_checker.sv @@
// ----------------------------------------------------------------------------
// ialu_checker: port-level checks for the integer ALU
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ialu_checker (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              req_valid,
	input wire logic                              req_ready,
	input wire logic                              rsp_valid,
	input wire logic                              rsp_ready,
	input wire logic [ialu_pkg::RES_W-1:0]        result_value,
	input wire logic [1:0]                        status_code
);

	// Words accepted and not yet delivered.
	logic [1:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + {1'b0, req_valid && req_ready}
				- {1'b0, rsp_valid && rsp_ready};
		end
	end

	// A stalled result word holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_value) && $stable(status_code))
		else $error("response word changed while stalled");

	// One request at a time: after an accept the block is busy.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted back to back");

	// Any error reports a zero result.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status_code != ialu_pkg::ST_OK |-> result_value == '0)
		else $error("error status with nonzero result");

	// No result without a request behind it, and at most two words in the block.
	a_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid |-> inflight_q != 2'd0) and (inflight_q != 2'd3))
		else $error("response count does not match requests");

endmodule

bind integer_alu_with_gcd_lcm ialu_checker u_ialu_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.result_value (rsp.result_value),
	.status_code  (rsp.status_code)
);

`default_nettype wire
